[rtl/wpm_pkg.sv]
// Package: shared types, request codes and defaults for the wildcard pattern matcher.
package wpm_pkg;

	localparam int MAX_PATTERN_DEF = 32;
	localparam int CHAR_BITS_DEF   = 16;

	localparam logic [15:0] STAR_RESET = 16'd42;
	localparam logic [15:0] ANY_RESET  = 16'd63;

	typedef enum logic [1:0] {
		REQ_CLEAR  = 2'd0,
		REQ_APPEND = 2'd1,
		REQ_TEXT   = 2'd2,
		REQ_END    = 2'd3
	} req_type_t;

	typedef enum logic {
		CFG_STAR_CODE = 1'b0,
		CFG_ANY_CODE  = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [15:0] char_code;
	} req_item_t;

	typedef struct packed {
		logic matched;
		logic pattern_overflow;
	} rsp_item_t;

	typedef struct packed {
		logic clear;
		logic append;
	} store_ctrl_t;

endpackage

[rtl/wpm_pattern_store.sv]
// Pattern store: character registers, length, overflow flag and per-position compares.
module wpm_pattern_store #(
	parameter int MAX_PATTERN = wpm_pkg::MAX_PATTERN_DEF,
	parameter int CHAR_BITS   = wpm_pkg::CHAR_BITS_DEF,
	localparam int LW         = $clog2(MAX_PATTERN + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  wpm_pkg::store_ctrl_t    ctrl,
	input  logic [CHAR_BITS-1:0]    char_code,
	input  logic [CHAR_BITS-1:0]    star_code,
	input  logic [CHAR_BITS-1:0]    any_code,
	output logic [MAX_PATTERN-1:0]  star_vec,
	output logic [MAX_PATTERN-1:0]  match_vec,
	output logic [LW-1:0]           pattern_length,
	output logic                    overflow
);
	import wpm_pkg::*;

	logic [CHAR_BITS-1:0] store_q [MAX_PATTERN];
	logic [LW-1:0]        len_q;
	logic                 ovf_q;
	logic                 full;

	assign full = (len_q == LW'(MAX_PATTERN));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			ovf_q <= 1'b0;
		end else if (ctrl.clear) begin
			len_q <= '0;
			ovf_q <= 1'b0;
		end else if (ctrl.append) begin
			if (full) begin
				ovf_q <= 1'b1;
			end else begin
				len_q <= len_q + LW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if (ctrl.append && !ctrl.clear && !full && len_q == LW'(i)) begin
				store_q[i] <= char_code;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_PATTERN; i++) begin
			logic in_use;
			logic is_star;
			in_use       = (LW'(i) < len_q);
			is_star      = (store_q[i] == star_code);
			star_vec[i]  = in_use && is_star;
			match_vec[i] = in_use && !is_star &&
				((store_q[i] == any_code) || (store_q[i] == char_code));
		end
	end

	assign pattern_length = len_q;
	assign overflow       = ovf_q;

endmodule

[rtl/wpm_closure.sv]
// Star closure: parallel-prefix spread of live positions across runs of stars.
module wpm_closure #(
	parameter int MAX_PATTERN = wpm_pkg::MAX_PATTERN_DEF
) (
	input  logic [MAX_PATTERN:0]   live,
	input  logic [MAX_PATTERN-1:0] star_vec,
	output logic [MAX_PATTERN:0]   closed
);
	import wpm_pkg::*;

	localparam int N    = MAX_PATTERN + 1;
	localparam int LVLS = $clog2(N);

	logic [N-1:0] g [LVLS+1];
	logic [N-1:0] p [LVLS+1];

	// p[j]: a star at position j-1 carries a live bit into position j
	always_comb begin
		g[0] = live;
		p[0] = {star_vec, 1'b0};
		for (int l = 0; l < LVLS; l++) begin
			for (int j = 0; j < N; j++) begin
				if (j >= (1 << l)) begin
					g[l+1][j] = g[l][j] | (p[l][j] & g[l][j - (1 << l)]);
					p[l+1][j] = p[l][j] & p[l][j - (1 << l)];
				end else begin
					g[l+1][j] = g[l][j];
					p[l+1][j] = 1'b0;
				end
			end
		end
		closed = g[LVLS];
	end

endmodule

[rtl/wildcard_pattern_matcher_core.sv]
// Top level: glob matcher with star and any codes over a streamed text.
// Result path: an end-of-text request waits in the input register while an earlier
// result is still held, then its result is written into the result register.
// Throughput: one request per cycle; ready drops only while a result waits and
// the next end-of-text request stands in the input register.
// Reset: empty pattern, no overflow, star code 42, any code 63; no clearing pass.
module wildcard_pattern_matcher_core #(
	parameter int MAX_PATTERN = wpm_pkg::MAX_PATTERN_DEF,
	parameter int CHAR_BITS   = wpm_pkg::CHAR_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [15:0]         cfg_data,
	input  logic                req_valid,
	output logic                req_ready,
	input  wpm_pkg::req_item_t  req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output wpm_pkg::rsp_item_t  rsp
);
	import wpm_pkg::*;

	localparam int LW = $clog2(MAX_PATTERN + 1);
	localparam logic [CHAR_BITS-1:0] STAR_INIT = CHAR_BITS'(STAR_RESET);
	localparam logic [CHAR_BITS-1:0] ANY_INIT  = CHAR_BITS'(ANY_RESET);

	logic [CHAR_BITS-1:0] star_code_q;
	logic [CHAR_BITS-1:0] any_code_q;

	logic                 valid_s1;
	req_item_t            item_s1;
	logic                 advance;
	logic                 is_end;
	logic [CHAR_BITS-1:0] char_s1;

	logic [MAX_PATTERN:0]   live_q;
	logic [MAX_PATTERN:0]   cur;
	logic [MAX_PATTERN:0]   nxt;
	logic [MAX_PATTERN-1:0] star_vec;
	logic [MAX_PATTERN-1:0] match_vec;
	logic [LW-1:0]          pattern_length;
	logic                   overflow;
	store_ctrl_t            ctrl;

	logic      rsp_valid_q;
	rsp_item_t rsp_q;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			star_code_q <= STAR_INIT;
			any_code_q  <= ANY_INIT;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_STAR_CODE: star_code_q <= CHAR_BITS'(cfg_data);
				CFG_ANY_CODE:  any_code_q  <= CHAR_BITS'(cfg_data);
				default: ;
			endcase
		end
	end

	// input register
	assign is_end    = (item_s1.req_type == REQ_END);
	assign advance   = valid_s1 && (!is_end || !rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || advance;
	assign char_s1   = CHAR_BITS'(item_s1.char_code);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			item_s1 <= req;
		end
	end

	assign ctrl.clear  = advance && (item_s1.req_type == REQ_CLEAR);
	assign ctrl.append = advance && (item_s1.req_type == REQ_APPEND);

	wpm_pattern_store #(
		.MAX_PATTERN (MAX_PATTERN),
		.CHAR_BITS   (CHAR_BITS)
	) u_store (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (ctrl),
		.char_code      (char_s1),
		.star_code      (star_code_q),
		.any_code       (any_code_q),
		.star_vec       (star_vec),
		.match_vec      (match_vec),
		.pattern_length (pattern_length),
		.overflow       (overflow)
	);

	wpm_closure #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_closure (
		.live     (live_q),
		.star_vec (star_vec),
		.closed   (cur)
	);

	always_comb begin
		nxt = '0;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			nxt[i]   = nxt[i] | (cur[i] & star_vec[i]);
			nxt[i+1] = cur[i] & match_vec[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= (MAX_PATTERN+1)'(1);
		end else if (advance) begin
			case (item_s1.req_type)
				REQ_CLEAR:  live_q <= (MAX_PATTERN+1)'(1);
				REQ_APPEND: live_q <= live_q;
				REQ_TEXT:   live_q <= nxt;
				REQ_END:    live_q <= (MAX_PATTERN+1)'(1);
				default:    live_q <= live_q;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance && is_end) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_end) begin
			rsp_q.matched          <= cur[pattern_length] && !overflow;
			rsp_q.pattern_overflow <= overflow;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[bench/wildcard_pattern_matcher_core_tb.sv]
// Self-checking bench for the glob matcher core: a directed table, then randomized glob traffic.
module wildcard_pattern_matcher_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import wpm_pkg::*;

	localparam int MAXP = MAX_PATTERN_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 280;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 4;

	typedef struct packed {
		req_type_t kind;
		logic [15:0] code;
		logic [5:0] reps;
		logic typed;
		logic m;
		logic o;
	} dir_row_t;

	localparam int DIR_ROWS = 28;
	localparam dir_row_t DIR_TAB [0:DIR_ROWS-1] = '{
		'{REQ_END,    16'h0000, 6'd1,  1'b1, 1'b1, 1'b0},
		'{REQ_TEXT,   16'h0061, 6'd1,  1'b0, 1'b0, 1'b0},
		'{REQ_END,    16'h0000, 6'd1,  1'b1, 1'b0, 1'b0},
		'{REQ_APPEND, STAR_RESET, 6'd1, 1'b0, 1'b0, 1'b0},
		'{REQ_TEXT,   16'h0000, 6'd1,  1'b0, 1'b0, 1'b0},
		'{REQ_TEXT,   16'hFFFF, 6'd1,  1'b0, 1'b0, 1'b0},
		'{REQ_END,    16'h0000, 6'd1,  1'b1, 1'b1, 1'b0},
		'{REQ_END,    16'hFFFF, 6'd1,  1'b1, 1'b1, 1'b0},
		'{REQ_CLEAR,  16'hFFFF, 6'd1,  1'b0, 1'b0, 1'b0},
		'{REQ_APPEND, 16'h0061, 6'd1,  1'b0, 1'b0, 1'b0},
		'{REQ_APPEND, ANY_RESET, 6'd1, 1'b0, 1'b0, 1'b0},
		'{REQ_APPEND, 16'hFFFF, 6'd1,  1'b0, 1'b0, 1'b0},
		'{REQ_TEXT,   16'h0061, 6'd1,  1'b0, 1'b0, 1'b0},
		'{REQ_TEXT,   16'h0000, 6'd1,  1'b0, 1'b0, 1'b0},
		'{REQ_TEXT,   16'hFFFF, 6'd1,  1'b0, 1'b0, 1'b0},
		'{REQ_END,    16'h0000, 6'd1,  1'b0, 1'b0, 1'b0},
		'{REQ_CLEAR,  16'h0000, 6'd1,  1'b0, 1'b0, 1'b0},
		'{REQ_APPEND, 16'h0061, 6'd1,  1'b0, 1'b0, 1'b0},
		'{REQ_TEXT,   16'h0061, 6'd1,  1'b0, 1'b0, 1'b0},
		'{REQ_APPEND, 16'h0062, 6'd1,  1'b0, 1'b0, 1'b0},
		'{REQ_TEXT,   16'h0062, 6'd1,  1'b0, 1'b0, 1'b0},
		'{REQ_END,    16'h0000, 6'd1,  1'b0, 1'b0, 1'b0},
		'{REQ_APPEND, 16'h0078, 6'd33, 1'b0, 1'b0, 1'b0},
		'{REQ_END,    16'h0000, 6'd1,  1'b1, 1'b0, 1'b1},
		'{REQ_TEXT,   16'h0078, 6'd1,  1'b0, 1'b0, 1'b0},
		'{REQ_END,    16'h0000, 6'd1,  1'b1, 1'b0, 1'b1},
		'{REQ_CLEAR,  16'h0000, 6'd1,  1'b0, 1'b0, 1'b0},
		'{REQ_END,    16'h0000, 6'd1,  1'b1, 1'b1, 1'b0}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_index;
	logic [15:0] cfg_data;
	logic req_valid;
	logic req_ready;
	req_item_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_item_t rsp;

	wildcard_pattern_matcher_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	// matcher model state
	logic [15:0] star_r = STAR_RESET;
	logic [15:0] any_r = ANY_RESET;
	logic [15:0] pat_mem [0:MAXP-1];
	int pat_len = 0;
	logic [MAXP:0] live = 1;
	logic ovf = 1'b0;

	rsp_item_t pending_verdicts [$];
	int mismatches = 0;
	int sent = 0;
	int idle_phase = 0;
	bit hold_req = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [MAXP:0] star_close(logic [MAXP:0] v);
		for (int i = 0; i < pat_len; i++)
			if (v[i] && pat_mem[i] == star_r)
				v[i+1] = 1'b1;
		return v;
	endfunction

	function automatic bit step_matcher(input req_item_t it, output rsp_item_t verdict);
		logic [MAXP:0] cur;
		logic [MAXP:0] nxt;
		verdict = '0;
		case (it.req_type)
			REQ_CLEAR: begin
				pat_len = 0;
				ovf = 1'b0;
				live = 1;
			end
			REQ_APPEND: begin
				if (pat_len < MAXP) begin
					pat_mem[pat_len] = it.char_code;
					pat_len++;
				end else begin
					ovf = 1'b1;
				end
			end
			REQ_TEXT: begin
				cur = star_close(live);
				nxt = '0;
				for (int i = 0; i < pat_len; i++) begin
					if (cur[i]) begin
						if (pat_mem[i] == star_r)
							nxt[i] = 1'b1;
						else if (pat_mem[i] == any_r || pat_mem[i] == it.char_code)
							nxt[i+1] = 1'b1;
					end
				end
				live = nxt;
			end
			default: begin
				cur = star_close(live);
				verdict.matched = cur[pat_len] && !ovf;
				verdict.pattern_overflow = ovf;
				live = 1;
				return 1'b1;
			end
		endcase
		return 1'b0;
	endfunction

	function automatic req_item_t req_of(req_type_t k, logic [15:0] c);
		req_item_t it;
		it.req_type = k;
		it.char_code = c;
		return it;
	endfunction

	function automatic logic [15:0] pick_char();
		case ($urandom_range(7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2, 3: return 16'h0061;
			4, 5: return 16'h0062;
			6: return 16'h0063;
			default: return 16'($urandom);
		endcase
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic send_item(input req_item_t it, input bit typed, input rsp_item_t want);
		rsp_item_t verdict;
		idle_phase = (sent < 500) ? 0 : (sent < 1000) ? 1 : 2;
		while ($urandom_range(99) < ((idle_phase == 0) ? 28 : (idle_phase == 1) ? 76 : 0)) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req = it;
		req_valid = 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		if (step_matcher(it, verdict))
			pending_verdicts.push_back(typed ? want : verdict);
		sent++;
		if (sent == 1100)
			hold_req = 1'b1;
		@(negedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
		cfg_index = idx;
		cfg_data = val;
		cfg_valid = 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == CFG_STAR_CODE)
			star_r = val;
		else
			any_r = val;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic wait_drained();
		req_valid = 1'b0;
		while (pending_verdicts.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic drive_glob_sequence();
		logic [15:0] pat [$];
		logic [15:0] txt [$];
		logic [15:0] ch;
		int plen_tgt;
		pat = {};
		send_item(req_of(REQ_CLEAR, 16'($urandom)), 1'b0, '0);
		plen_tgt = ($urandom_range(15) == 0) ? $urandom_range(30, 36) : $urandom_range(0, 7);
		for (int i = 0; i < plen_tgt; i++) begin
			case ($urandom_range(9))
				0, 1, 2: ch = star_r;
				3, 4: ch = any_r;
				default: ch = pick_char();
			endcase
			pat.push_back(ch);
			send_item(req_of(REQ_APPEND, ch), 1'b0, '0);
		end
		repeat ($urandom_range(1, 3)) begin
			txt = {};
			if ($urandom_range(9) < 6) begin
				foreach (pat[i]) begin
					if (pat[i] == star_r)
						repeat ($urandom_range(0, 3)) txt.push_back(pick_char());
					else if (pat[i] == any_r)
						txt.push_back(pick_char());
					else
						txt.push_back(pat[i]);
				end
				if (txt.size() > 0 && $urandom_range(3) == 0)
					txt[$urandom_range(txt.size() - 1)] = pick_char();
			end else begin
				repeat ($urandom_range(0, 8)) txt.push_back(pick_char());
			end
			foreach (txt[i]) begin
				if ($urandom_range(39) == 0)
					send_item(req_of(REQ_APPEND, pick_char()), 1'b0, '0);
				send_item(req_of(REQ_TEXT, txt[i]), 1'b0, '0);
			end
			send_item(req_of(REQ_END, 16'($urandom)), 1'b0, '0);
		end
	endtask

	// result receiver with random stalls and one long hold-off
	initial begin
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		rsp_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				rsp_ready = 1'b0;
				hold_left--;
			end else begin
				rsp_ready = $urandom_range(99) >=
					((idle_phase == 0) ? 76 : (idle_phase == 1) ? 28 : 0);
			end
		end
	end

	always @(posedge clk) begin
		rsp_item_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_verdicts.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result: matched=%0b overflow=%0b",
						rsp.matched, rsp.pattern_overflow);
				mismatches++;
			end else begin
				want = pending_verdicts.pop_front();
				if (rsp.matched !== want.matched ||
					rsp.pattern_overflow !== want.pattern_overflow) begin
					if (mismatches < 10)
						$display("result mismatch: expected matched=%0b overflow=%0b, got matched=%0b overflow=%0b",
							want.matched, want.pattern_overflow,
							rsp.matched, rsp.pattern_overflow);
					mismatches++;
				end
			end
		end
	end

	initial begin
		int cyc;
		cyc = 0;
		while (cyc < CYCLE_LIMIT) begin
			@(posedge clk);
			cyc++;
		end
		$display("wildcard_pattern_matcher_core verification failed");
		$finish;
	end

	initial begin
		logic [15:0] star_set [0:4];
		logic [15:0] any_set [0:4];
		int phase_start;
		star_set = '{16'h0000, 16'hFFFF, 16'h0007, 16'($urandom), STAR_RESET};
		any_set = '{16'hFFFF, 16'h0000, 16'h0007, 16'($urandom), ANY_RESET};
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_STAR_CODE;
		cfg_data = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int r = 0; r < DIR_ROWS; r++)
			repeat (DIR_TAB[r].reps)
				send_item(req_of(DIR_TAB[r].kind, DIR_TAB[r].code), DIR_TAB[r].typed,
					'{matched: DIR_TAB[r].m, pattern_overflow: DIR_TAB[r].o});

		for (int p = 0; p < 5; p++) begin
			wait_drained();
			if (p[0]) begin
				write_reg(CFG_ANY_CODE, any_set[p]);
				write_reg(CFG_STAR_CODE, star_set[p]);
			end else begin
				write_reg(CFG_STAR_CODE, star_set[p]);
				write_reg(CFG_ANY_CODE, any_set[p]);
			end
			phase_start = sent;
			while (sent - phase_start < PHASE_ITEMS) begin
				if ($urandom_range(99) < 85)
					drive_glob_sequence();
				else
					send_item(req_of(req_type_t'($urandom_range(3)), 16'($urandom)), 1'b0, '0);
			end
		end

		wait_drained();
		if (mismatches == 0 && pending_verdicts.size() == 0)
			$display("wildcard_pattern_matcher_core verification clean");
		else
			$display("wildcard_pattern_matcher_core verification failed");
		$finish;
	end

endmodule

[sim.f]
rtl/wpm_pkg.sv
rtl/wpm_pattern_store.sv
rtl/wpm_closure.sv
rtl/wildcard_pattern_matcher_core.sv
bench/wildcard_pattern_matcher_core_tb.sv
